// ===== sv/assert_macros.svh =====
// Assertion macros shared by the speed regulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dmsr_pkg.sv =====
// Types, constants and helpers of the DC motor speed regulator.
package dmsr_pkg;

  // Key positions in the 4-bit key vector.
  localparam int unsigned KeyRun  = 0;
  localparam int unsigned KeyHalt = 1;
  localparam int unsigned KeyUp   = 2;
  localparam int unsigned KeyDown = 3;

  // Drive bits: bit 0 is terminal A, bit 1 is terminal B.
  localparam logic [1:0] DriveOn    = 2'b01;
  localparam logic [1:0] DriveBrake = 2'b11;

  localparam logic [7:0]  PwmPeriodRst   = 8'd100;
  localparam logic [15:0] SampleTicksRst = 16'd1000;
  localparam logic [7:0]  TargetMaxRst   = 8'd60;
  localparam logic [7:0]  TargetMinRst   = 8'd1;
  localparam logic [7:0]  TargetRst      = 8'd40;

  // ceil(2^19 / 3): exact quotient for every dividend below 2^19.
  localparam logic [17:0] Div3Mul = 18'd174763;

  typedef enum logic [7:0] {
    REG_PWM_PERIOD   = 8'd0,
    REG_SAMPLE_TICKS = 8'd1,
    REG_TARGET_MAX   = 8'd2,
    REG_TARGET_MIN   = 8'd3
  } dmsr_reg_e;

  typedef struct packed {
    logic [7:0]  pwm_period;
    logic [15:0] sample_ticks;
    logic [7:0]  target_max;
    logic [7:0]  target_min;
  } dmsr_cfg_t;

  // Outcome of one tick, with the running sum of the speed history.
  typedef struct packed {
    logic        drive_a;
    logic        drive_b;
    logic        running;
    logic [7:0]  target_speed;
    logic [7:0]  duty;
    logic [17:0] hist_sum;
    logic        sample_done;
  } dmsr_res_t;

  typedef struct packed {
    logic        drive_a;
    logic        drive_b;
    logic        running;
    logic [7:0]  target_speed;
    logic [7:0]  duty;
    logic [15:0] average_speed;
    logic        sample_done;
  } dmsr_out_t;

  // Divide a sum of three 16-bit samples by three.
  function automatic logic [15:0] dmsr_div3(input logic [17:0] x);
    logic [35:0] prod;
    prod = 36'(x) * 36'(Div3Mul);
    return prod[34:19];
  endfunction

endpackage

// ===== sv/dmsr_ifs.sv =====
// Channel interfaces: tick input, result output, configuration writes.
interface dmsr_tick_if;
  logic       valid;
  logic       ready;
  logic       run_key;
  logic       halt_key;
  logic       up_key;
  logic       down_key;
  logic [7:0] pulses;

  modport source(output valid, run_key, halt_key, up_key, down_key, pulses, input ready);
  modport sink(input valid, run_key, halt_key, up_key, down_key, pulses, output ready);
endinterface

interface dmsr_res_if;
  logic        valid;
  logic        ready;
  logic        drive_a;
  logic        drive_b;
  logic        running;
  logic [7:0]  target_speed;
  logic [7:0]  duty;
  logic [15:0] average_speed;
  logic        sample_done;

  modport source(output valid, drive_a, drive_b, running, target_speed, duty,
                 average_speed, sample_done, input ready);
  modport sink(input valid, drive_a, drive_b, running, target_speed, duty,
               average_speed, sample_done, output ready);
endinterface

interface dmsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/dmsr_cfg_regs.sv =====
// Configuration register file of the speed regulator.
module dmsr_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  dmsr_cfg_if.sink            cfg_i,
  output dmsr_pkg::dmsr_cfg_t cfg_o
);
  import dmsr_pkg::*;

  dmsr_cfg_t cfg_q;
  dmsr_cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (dmsr_reg_e'(cfg_i.index))
        REG_PWM_PERIOD:   cfg_d.pwm_period   = cfg_i.data[7:0];
        REG_SAMPLE_TICKS: cfg_d.sample_ticks = cfg_i.data;
        REG_TARGET_MAX:   cfg_d.target_max   = cfg_i.data[7:0];
        REG_TARGET_MIN:   cfg_d.target_min   = cfg_i.data[7:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period   <= PwmPeriodRst;
      cfg_q.sample_ticks <= SampleTicksRst;
      cfg_q.target_max   <= TargetMaxRst;
      cfg_q.target_min   <= TargetMinRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/dmsr_core.sv =====
// Regulator state and per-tick update: keys, PWM, pulse count, sampling, duty.
`include "assert_macros.svh"

module dmsr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [3:0]          keys_i,
  input  logic [7:0]          pulses_i,
  input  dmsr_pkg::dmsr_cfg_t cfg_i,
  output dmsr_pkg::dmsr_res_t res_o
);
  import dmsr_pkg::*;

  logic [3:0]  prev_q,  prev_d;
  logic        run_q,   run_d;
  logic [7:0]  tgt_q,   tgt_d;
  logic [7:0]  duty_q,  duty_d;
  logic [7:0]  pwm_q,   pwm_d;
  logic [15:0] tick_q,  tick_d;
  logic [15:0] total_q, total_d;
  logic [15:0] h0_q, h0_d, h1_q, h1_d, h2_q, h2_d;
  logic [17:0] sum_q,   sum_d;
  logic [1:0]  drive_q, drive_d;

  logic [3:0]  rel;
  logic [8:0]  up_sum;
  logic [7:0]  pwm_inc;
  logic [15:0] tick_inc;
  logic [15:0] acc;
  logic [15:0] mean_old;
  logic [7:0]  raise;
  logic [8:0]  duty_up;
  logic [15:0] over;
  logic [14:0] drop;
  logic        sample;

  always_comb begin
    rel      = keys_i & ~prev_q;
    prev_d   = keys_i;
    run_d    = run_q;
    tgt_d    = tgt_q;
    duty_d   = duty_q;
    pwm_d    = pwm_q;
    tick_d   = tick_q;
    total_d  = total_q;
    h0_d     = h0_q;
    h1_d     = h1_q;
    h2_d     = h2_q;
    sum_d    = sum_q;
    drive_d  = drive_q;
    sample   = 1'b0;
    up_sum   = {1'b0, tgt_q} + 9'd1;
    pwm_inc  = pwm_q + 8'd1;
    tick_inc = tick_q + 16'd1;
    acc      = total_q + {8'd0, pulses_i};
    mean_old = dmsr_div3(sum_q);
    raise    = '0;
    duty_up  = '0;
    over     = '0;
    drop     = '0;

    // Keys act on release, in the order run, halt, up, down.
    if (rel[KeyRun]) begin
      run_d = 1'b1;
    end
    if (rel[KeyHalt]) begin
      run_d   = 1'b0;
      drive_d = DriveBrake;
    end
    if (rel[KeyUp] && run_d) begin
      tgt_d = (up_sum >= {1'b0, cfg_i.target_max}) ? cfg_i.target_max : up_sum[7:0];
    end
    if (rel[KeyDown] && run_d) begin
      // target - 1 <= min, with zero counting as below every limit
      tgt_d = ({1'b0, tgt_d} <= ({1'b0, cfg_i.target_min} + 9'd1)) ?
              cfg_i.target_min : tgt_d - 8'd1;
    end

    if (run_d) begin
      pwm_d   = (pwm_inc == cfg_i.pwm_period) ? 8'd0 : pwm_inc;
      drive_d = (pwm_d < duty_q) ? DriveOn : DriveBrake;
      total_d = acc;
      tick_d  = tick_inc;
      if (tick_inc == cfg_i.sample_ticks) begin
        sample  = 1'b1;
        tick_d  = '0;
        total_d = '0;
        h0_d    = h1_q;
        h1_d    = h2_q;
        h2_d    = acc;
        sum_d   = sum_q - {2'b00, h0_q} + {2'b00, acc};
        // Move duty by half the error against the pre-shift average.
        if (mean_old < {8'd0, tgt_d}) begin
          raise   = tgt_d - mean_old[7:0];
          duty_up = {1'b0, duty_q} + {2'b00, raise[7:1]};
          duty_d  = duty_up[8] ? 8'hFF : duty_up[7:0];
        end else if (mean_old > {8'd0, tgt_d}) begin
          over   = mean_old - {8'd0, tgt_d};
          drop   = over[15:1];
          duty_d = (drop >= {7'd0, duty_q}) ? 8'd0 : duty_q - drop[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '1;
      run_q   <= 1'b0;
      tgt_q   <= TargetRst;
      duty_q  <= '0;
      pwm_q   <= '0;
      tick_q  <= '0;
      total_q <= '0;
      h0_q    <= '0;
      h1_q    <= '0;
      h2_q    <= '0;
      sum_q   <= '0;
      drive_q <= DriveBrake;
    end else if (step_i) begin
      prev_q  <= prev_d;
      run_q   <= run_d;
      tgt_q   <= tgt_d;
      duty_q  <= duty_d;
      pwm_q   <= pwm_d;
      tick_q  <= tick_d;
      total_q <= total_d;
      h0_q    <= h0_d;
      h1_q    <= h1_d;
      h2_q    <= h2_d;
      sum_q   <= sum_d;
      drive_q <= drive_d;
    end
  end

  assign res_o.drive_a      = drive_d[0];
  assign res_o.drive_b      = drive_d[1];
  assign res_o.running      = run_d;
  assign res_o.target_speed = tgt_d;
  assign res_o.duty         = duty_d;
  assign res_o.hist_sum     = sum_d;
  assign res_o.sample_done  = sample;

  `ASSERT_ON(a_sum_tracks_history, sum_q == ({2'b00, h0_q} + {2'b00, h1_q} + {2'b00, h2_q}), "history sum out of step with samples")
  `ASSERT_ON(a_terminal_a_high, drive_q[0], "terminal A dropped low")
  `ASSERT_NXT(a_duty_only_on_sample, !(step_i && sample), $stable(duty_q), "duty moved without a sample")

endmodule

// ===== sv/dmsr_out_stage.sv =====
// Result register: forms the history average and holds the outgoing result.
module dmsr_out_stage (
  input  logic                clk_i,
  input  logic                load_i,
  input  dmsr_pkg::dmsr_res_t res_i,
  output dmsr_pkg::dmsr_out_t out_o
);
  import dmsr_pkg::*;

  dmsr_out_t out_q;
  dmsr_out_t out_d;

  always_comb begin
    out_d.drive_a       = res_i.drive_a;
    out_d.drive_b       = res_i.drive_b;
    out_d.running       = res_i.running;
    out_d.target_speed  = res_i.target_speed;
    out_d.duty          = res_i.duty;
    out_d.average_speed = dmsr_div3(res_i.hist_sum);
    out_d.sample_done   = res_i.sample_done;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ===== sv/dc_motor_speed_regulator_core.sv =====
// Top level of the DC motor speed regulator: tick pipeline and result channel.
// A tick passes the tick register and state update, then shows from the result register.
// Throughput: one tick per cycle; the three stages (tick register, state update,
// average and result register) advance together whenever the result register is free
// or its result is transferred, so a held result stalls the whole pipeline.
// Reset: asynchronous, active low; clears stage valids, regulator state and config registers to defaults.
`include "assert_macros.svh"

module dc_motor_speed_regulator_core (
  input logic           clk_i,
  input logic           rst_ni,
  dmsr_tick_if.sink     tick_i,
  dmsr_res_if.source    res_o,
  dmsr_cfg_if.sink      cfg_i
);
  import dmsr_pkg::*;

  // Stage valids: v0 tick register, v1 state-update result, v2 output register.
  logic       v0_q, v0_d;
  logic       v1_q, v1_d;
  logic       v2_q, v2_d;
  logic       adv;
  logic       accept;
  logic       step;

  logic [3:0] keys_q;
  logic [7:0] pulses_q;
  dmsr_res_t  core_res;
  dmsr_res_t  s1_q;
  dmsr_cfg_t  cfg;
  dmsr_out_t  out;

  // Advance the pipeline when the output register is empty or being drained.
  assign adv          = !v2_q || res_o.ready;
  assign tick_i.ready = !v0_q || adv;
  assign accept       = tick_i.valid && tick_i.ready;
  // Apply a tick to the regulator state exactly once, as it leaves stage 0.
  assign step         = v0_q && adv;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    v2_d = v2_q;
    if (adv) begin
      v0_d = 1'b0;
      v1_d = v0_q;
      v2_d = v1_q;
    end
    if (accept) begin
      v0_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  // Capture the tick payload on transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      keys_q   <= {tick_i.down_key, tick_i.up_key, tick_i.halt_key, tick_i.run_key};
      pulses_q <= tick_i.pulses;
    end
  end

  dmsr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  dmsr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .keys_i   (keys_q),
    .pulses_i (pulses_q),
    .cfg_i    (cfg),
    .res_o    (core_res)
  );

  // Hold the tick outcome while the average is formed in the next stage.
  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_q <= core_res;
    end
  end

  dmsr_out_stage u_out (
    .clk_i  (clk_i),
    .load_i (adv && v1_q),
    .res_i  (s1_q),
    .out_o  (out)
  );

  assign res_o.valid         = v2_q;
  assign res_o.drive_a       = out.drive_a;
  assign res_o.drive_b       = out.drive_b;
  assign res_o.running       = out.running;
  assign res_o.target_speed  = out.target_speed;
  assign res_o.duty          = out.duty;
  assign res_o.average_speed = out.average_speed;
  assign res_o.sample_done   = out.sample_done;

  `ASSERT_NXT(a_accept_fills_stage0, accept, v0_q, "transferred tick not held in stage 0")
  `ASSERT_NXT(a_step_fills_stage1, step, v1_q, "stepped tick lost before the result stage")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the DC motor speed regulator core.
`timescale 1ns / 100ps

import dmsr_pkg::*;

// Tracks the regulator state tick by tick and checks every result in order.
class regulator_tracker;
  logic [7:0]  pwm_period;
  logic [15:0] sample_ticks;
  logic [7:0]  target_max;
  logic [7:0]  target_min;

  logic [3:0]  prev_keys;
  bit          run_flag;
  logic [7:0]  target;
  logic [7:0]  duty;
  logic [7:0]  pwm_count;
  logic [15:0] tick_count;
  logic [15:0] pulse_total;
  logic [15:0] hist [3];
  logic [1:0]  drive_bits;

  dmsr_out_t   expected_q [$];
  int unsigned errors;

  function new();
    pwm_period   = PwmPeriodRst;
    sample_ticks = SampleTicksRst;
    target_max   = TargetMaxRst;
    target_min   = TargetMinRst;
    prev_keys    = 4'hF;
    run_flag     = 1'b0;
    target       = TargetRst;
    duty         = 8'd0;
    pwm_count    = 8'd0;
    tick_count   = 16'd0;
    pulse_total  = 16'd0;
    hist[0]      = 16'd0;
    hist[1]      = 16'd0;
    hist[2]      = 16'd0;
    drive_bits   = DriveBrake;
    errors       = 0;
  endfunction

  function void set_reg(dmsr_reg_e idx, logic [15:0] val);
    case (idx)
      REG_PWM_PERIOD:   pwm_period   = val[7:0];
      REG_SAMPLE_TICKS: sample_ticks = val;
      REG_TARGET_MAX:   target_max   = val[7:0];
      REG_TARGET_MIN:   target_min   = val[7:0];
      default: ;
    endcase
  endfunction

  function int unsigned hist_mean();
    int unsigned sum;
    sum = hist[0] + hist[1] + hist[2];
    return sum / 3;
  endfunction

  // Note one accepted tick and queue the result it must produce.
  function void take_tick(logic [3:0] keys, logic [7:0] pulses);
    logic [3:0]  rel;
    int unsigned up_t;
    int          dn_t;
    int unsigned avg;
    int unsigned acc;
    bit          sampled;
    dmsr_out_t   exp_out;
    rel     = ~prev_keys & keys;
    sampled = 1'b0;
    if (rel[KeyRun]) begin
      run_flag = 1'b1;
    end
    if (rel[KeyHalt]) begin
      run_flag   = 1'b0;
      drive_bits = DriveBrake;
    end
    if (rel[KeyUp] && run_flag) begin
      up_t = target + 1;
      target = (up_t >= target_max) ? target_max : up_t[7:0];
    end
    if (rel[KeyDown] && run_flag) begin
      dn_t = int'(target) - 1;
      target = (dn_t <= int'(target_min)) ? target_min : dn_t[7:0];
    end
    prev_keys = keys;
    if (run_flag) begin
      pwm_count = pwm_count + 8'd1;
      if (pwm_count == pwm_period) pwm_count = 8'd0;
      drive_bits  = (pwm_count < duty) ? DriveOn : DriveBrake;
      pulse_total = pulse_total + 16'(pulses);
      tick_count  = tick_count + 16'd1;
      if (tick_count == sample_ticks) begin
        avg         = hist_mean();
        tick_count  = 16'd0;
        hist[0]     = hist[1];
        hist[1]     = hist[2];
        hist[2]     = pulse_total;
        pulse_total = 16'd0;
        if (avg < target) begin
          acc  = duty + (target - avg) / 2;
          duty = (acc > 255) ? 8'd255 : acc[7:0];
        end else if (avg > target) begin
          acc  = (avg - target) / 2;
          duty = (acc >= duty) ? 8'd0 : duty - acc[7:0];
        end
        sampled = 1'b1;
      end
    end
    exp_out.drive_a       = drive_bits[0];
    exp_out.drive_b       = drive_bits[1];
    exp_out.running       = run_flag;
    exp_out.target_speed  = target;
    exp_out.duty          = duty;
    exp_out.average_speed = 16'(hist_mean());
    exp_out.sample_done   = sampled;
    expected_q.push_back(exp_out);
  endfunction

  function void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // Check one transferred result against the oldest expectation.
  function void match_result(dmsr_out_t got);
    dmsr_out_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: result with none expected, expected none got %p", $time, got);
      return;
    end
    want = expected_q.pop_front();
    cmp_field("drive_a", want.drive_a, got.drive_a);
    cmp_field("drive_b", want.drive_b, got.drive_b);
    cmp_field("running", want.running, got.running);
    cmp_field("target_speed", want.target_speed, got.target_speed);
    cmp_field("duty", want.duty, got.duty);
    cmp_field("average_speed", want.average_speed, got.average_speed);
    cmp_field("sample_done", want.sample_done, got.sample_done);
  endfunction
endclass

module tb;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned QuietLimit = 3000;
  // Cycles to let pass after the last result, so the pipeline settles.
  localparam int unsigned SettleCycles = 6;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  dmsr_tick_if tick_if();
  dmsr_res_if  res_if();
  dmsr_cfg_if  cfg_if();

  dc_motor_speed_regulator_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  regulator_tracker tracker = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Key vector with the given key held down (active low), the others released.
  function automatic logic [3:0] held(int unsigned k);
    return ~(4'b0001 << k);
  endfunction

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 58; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 58; end
      IDLE_BOTH: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      default: ;
    endcase
  endtask

  // Offer one tick, inserting random gaps first; return at the edge of its transfer.
  task automatic send_tick(input logic [3:0] keys, input logic [7:0] pulses);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid    <= 1'b1;
    tick_if.run_key  <= keys[KeyRun];
    tick_if.halt_key <= keys[KeyHalt];
    tick_if.up_key   <= keys[KeyUp];
    tick_if.down_key <= keys[KeyDown];
    tick_if.pulses   <= pulses;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    tracker.take_tick(keys, pulses);
  endtask

  // Drop the tick valid and hold until every queued result has been transferred.
  task automatic wait_drained();
    tick_if.valid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write; valid stays high so back-to-back writes need no gap.
  task automatic write_reg(input dmsr_reg_e idx, input logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  task automatic apply_setting(input logic [7:0] pwm, input logic [15:0] smp,
                               input logic [7:0] tmax, input logic [7:0] tmin);
    wait_drained();
    write_reg(REG_PWM_PERIOD, {8'd0, pwm});
    write_reg(REG_SAMPLE_TICKS, smp);
    write_reg(REG_TARGET_MAX, {8'd0, tmax});
    write_reg(REG_TARGET_MIN, {8'd0, tmin});
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly well-formed key activity: start when stopped, frequent up/down,
  // rare halts; a few ticks carry arbitrary key levels.
  function automatic logic [3:0] random_keys();
    logic [3:0] keys;
    keys = 4'hF;
    if ($urandom_range(99) < 8) begin
      keys = 4'($urandom());
    end else if (!tracker.run_flag) begin
      if ($urandom_range(99) < 40) keys[KeyRun] = 1'b0;
    end else begin
      if ($urandom_range(99) < 3)  keys[KeyHalt] = 1'b0;
      if ($urandom_range(99) < 6)  keys[KeyRun]  = 1'b0;
      if ($urandom_range(99) < 15) keys[KeyUp]   = 1'b0;
      if ($urandom_range(99) < 15) keys[KeyDown] = 1'b0;
    end
    return keys;
  endfunction

  function automatic logic [7:0] random_pulses(input int unsigned lo, input int unsigned hi);
    if ($urandom_range(99) < 5) begin
      return ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    end
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic run_phase(input logic [7:0] pwm, input logic [15:0] smp,
                           input logic [7:0] tmax, input logic [7:0] tmin,
                           input int unsigned plo, input int unsigned phi,
                           input int unsigned count, input idle_mode_e mode,
                           input bit pause_mid);
    logic [15:0] smp_eff;
    wait_drained();
    // The tick counter only clears on a sample; stretch the period past it so
    // samples keep coming instead of waiting for a 16-bit wrap.
    smp_eff = smp;
    if (tracker.tick_count >= smp) smp_eff = tracker.tick_count + smp;
    apply_setting(pwm, smp_eff, tmax, tmin);
    set_idle(mode);
    for (int unsigned i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) wait_drained();
      send_tick(random_keys(), random_pulses(plo, phi));
    end
  endtask

  // Result side: random stalls, and check every transfer.
  always @(posedge clk_i) begin
    dmsr_out_t got;
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.drive_a       = res_if.drive_a;
      got.drive_b       = res_if.drive_b;
      got.running       = res_if.running;
      got.target_speed  = res_if.target_speed;
      got.duty          = res_if.duty;
      got.average_speed = res_if.average_speed;
      got.sample_done   = res_if.sample_done;
      tracker.match_result(got);
    end
  end

  // Watchdog: end the run if no channel transfers anything for too long.
  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    tick_if.valid    <= 1'b0;
    tick_if.run_key  <= 1'b1;
    tick_if.halt_key <= 1'b1;
    tick_if.up_key   <= 1'b1;
    tick_if.down_key <= 1'b1;
    tick_if.pulses   <= 8'd0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_PWM_PERIOD;
    cfg_if.data      <= 16'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset settings: stopped block ignores pulses, up and halt.
    set_idle(IDLE_NONE);
    send_tick(4'hF, 8'd255);
    send_tick(held(KeyUp), 8'd0);
    send_tick(4'hF, 8'd3);
    send_tick(held(KeyHalt), 8'd0);
    send_tick(4'hF, 8'd0);

    // Directed, sample every tick, narrow target window around the reset target.
    apply_setting(8'd1, 16'd1, 8'd41, 8'd39);
    send_tick(held(KeyRun), 8'd0);
    send_tick(4'hF, 8'd0);
    // Run released while already running.
    send_tick(held(KeyRun), 8'd9);
    send_tick(4'hF, 8'd9);
    // Up twice: the first lands on the upper clamp, the second stays there.
    send_tick(held(KeyUp), 8'd0);
    send_tick(4'hF, 8'd0);
    send_tick(held(KeyUp), 8'd0);
    send_tick(4'hF, 8'd0);
    // Down twice with full-scale pulses: lower clamp and duty pulled to zero.
    send_tick(held(KeyDown), 8'd255);
    send_tick(4'hF, 8'd255);
    send_tick(held(KeyDown), 8'd255);
    send_tick(4'hF, 8'd255);
    // Up and down released in the same tick.
    send_tick(held(KeyUp) & held(KeyDown), 8'd255);
    send_tick(4'hF, 8'd255);
    // Run and halt released together: halt wins, then stay stopped.
    send_tick(held(KeyRun) & held(KeyHalt), 8'd0);
    send_tick(4'hF, 8'd255);
    send_tick(4'hF, 8'd0);

    // Random phases: settings, pulse range, length, idling.
    // Few pulses against a high target: duty saturates at the top.
    run_phase(8'd255, 16'd3, 8'd255, 8'd1, 0, 2, 120, IDLE_NONE, 1'b0);
    run_phase(8'd1, 16'd1, 8'd60, 8'd1, 0, 255, 120, IDLE_SEND, 1'b0);
    // Pause the sender mid-phase until every result is back.
    run_phase(8'd17, 16'd7, 8'd200, 8'd100, 0, 255, 120, IDLE_RECV, 1'b1);
    // Long sample window with heavy pulses: pulse total wraps.
    run_phase(8'd100, 16'd270, 8'd255, 8'd255, 250, 255, 360, IDLE_BOTH, 1'b0);
    // Lower clamp above upper clamp.
    run_phase(8'd5, 16'd2, 8'd10, 8'd200, 0, 40, 120, IDLE_NONE, 1'b0);
    run_phase(8'd254, 16'd4, 8'd1, 8'd1, 0, 255, 130, IDLE_RECV, 1'b0);
    // Longest sample window, shortest useful PWM cycle.
    run_phase(8'd2, 16'd65535, 8'd255, 8'd1, 0, 255, 60, IDLE_BOTH, 1'b0);

    wait_drained();
    if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/dmsr_pkg.sv
sv/dmsr_ifs.sv
sv/dmsr_cfg_regs.sv
sv/dmsr_core.sv
sv/dmsr_out_stage.sv
sv/dc_motor_speed_regulator_core.sv
dv/tb.sv
